>>> design/lpd_pkg.sv
// Shared types, codes and register defaults for the length-prefixed deframer.
package lpd_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int HEADER_BYTES   = 4;
    localparam int LEN_W          = 12;

    localparam logic [11:0] PAYLOAD_LIMIT_RST = 12'd2044;
    localparam logic [12:0] BUFFER_LIMIT_RST  = 13'd4096;
    localparam logic [6:0]  FRAMES_BUDGET_RST = 7'd64;
    localparam logic [12:0] BYTES_BUDGET_RST  = 13'd2048;

    typedef enum logic [1:0] {
        REG_PAYLOAD_LIMIT = 2'd0,
        REG_BUFFER_LIMIT  = 2'd1,
        REG_FRAMES_BUDGET = 2'd2,
        REG_BYTES_BUDGET  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        CMD_RESET = 3'd0,
        CMD_START = 3'd1,
        CMD_DATA  = 3'd2,
        CMD_END   = 3'd3,
        CMD_PULL  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_NEED_MORE   = 3'd0,
        ST_READY       = 3'd1,
        ST_BUDGET_OUT  = 3'd2,
        ST_BUFFER_OVER = 3'd3,
        ST_TOO_LARGE   = 3'd4,
        ST_FAULTED     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_END,
        S_WCHECK,
        S_WREAD,
        S_WEVAL,
        S_WDONE,
        S_PULL,
        S_PULLD,
        S_LEN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] chunk_length;
        logic [7:0]  data_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [6:0] frame_count;
        logic       needs_continuation;
        logic [7:0] data_out;
        logic       last_of_frame;
    } t_out_item;

endpackage

>>> design/length_prefixed_deframer.sv
// Length-prefixed deframer: a byte ring and a frame-length table, both in
// single-port-read RAMs with a registered read. A data byte is taken every
// cycle while the block is idle. A start_chunk is checked in S_START and,
// when it answers with a status, handed on through S_EMIT. A pull goes
// through the ring read, a frame-length table read when a frame ends, and the
// hand-off to the output register. end_chunk walks the headers, examining
// each with a length check, ring reads of its header bytes and an evaluation,
// and then reports a status; when the block is faulted it only reports a
// FAULTED status. The input is stalled meanwhile. A result waits in the
// output register until taken; a command that produces a result holds the
// input until that register is free, so a receiver stall also holds the input.
module length_prefixed_deframer #(
    parameter int RING_DEPTH = lpd_pkg::RING_DEPTH_DEF,
    parameter int MAX_FRAMES = lpd_pkg::MAX_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpd_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LW  = lpd_pkg::LEN_W;
    localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [16:0] DEPTH_17 = 17'(RING_DEPTH);
    localparam logic [8:0]  MAXF_9 = 9'(MAX_FRAMES);

    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_W) ? s - DEPTH_W : s;
        return t[AW-1:0];
    endfunction

    // Configuration registers
    logic [11:0] r_payload_limit, n_payload_limit;
    logic [12:0] r_buffer_limit, n_buffer_limit;
    logic [6:0]  r_frames_budget, n_frames_budget;
    logic [12:0] r_bytes_budget, n_bytes_budget;

    lpd_pkg::t_state r_state, n_state;
    logic [15:0]     r_clen, n_clen;
    logic [AW-1:0]   r_rh, n_rh;
    logic [FW-1:0]   r_fill, n_fill;
    logic            r_fault, n_fault;
    logic            r_open, n_open;
    logic [15:0]     r_left, n_left;
    logic [CW-1:0]   r_pend, n_pend;
    logic [CW-1:0]   r_fidx, n_fidx;
    logic [LW-1:0]   r_pleft, n_pleft;
    logic [AW-1:0]   r_dp, n_dp;
    logic [FW-1:0]   r_cons, n_cons;
    logic [CW-1:0]   r_count, n_count;
    logic            r_budget, n_budget;
    logic [2:0]      r_hb, n_hb;
    logic [31:0]     r_len, n_len;
    logic [LW-1:0]   r_first, n_first;
    lpd_pkg::t_out_item r_res, n_res;
    lpd_pkg::t_out_item r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            ring_we;
    logic [AW-1:0]   ring_waddr;
    logic [AW-1:0]   ring_raddr;
    logic [7:0]      ring_rdata;
    logic            fl_we;
    logic [FAW-1:0]  fl_raddr;
    logic [LW-1:0]   fl_rdata;

    logic            cfg_wr;
    logic            in_acc;
    logic            slot_free;
    logic [16:0]     cap17;
    logic [16:0]     free17;
    logic [FW-1:0]   avail;
    logic [12:0]     fbytes;
    logic [CW:0]     fidx_nx;
    logic [AW-1:0]   walk_addr;
    logic [AW-1:0]   new_rh;
    logic [FW-1:0]   new_fill;

    lpd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(ring_waddr),
        .i_wdata(i_in_item.data_in),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rdata)
    );

    lpd_ram #(.WIDTH(LW), .DEPTH(MAX_FRAMES)) u_flen (
        .i_clk  (i_clk),
        .i_we   (fl_we),
        .i_waddr(r_count[FAW-1:0]),
        .i_wdata(r_len[LW-1:0]),
        .i_raddr(fl_raddr),
        .o_rdata(fl_rdata)
    );

    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;
    assign o_in_stall  = (r_state != lpd_pkg::S_IDLE);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign slot_free   = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        case (lpd_pkg::t_reg_idx'(paddr[3:2]))
            lpd_pkg::REG_PAYLOAD_LIMIT: prdata = 32'(r_payload_limit);
            lpd_pkg::REG_BUFFER_LIMIT:  prdata = 32'(r_buffer_limit);
            lpd_pkg::REG_FRAMES_BUDGET: prdata = 32'(r_frames_budget);
            lpd_pkg::REG_BYTES_BUDGET:  prdata = 32'(r_bytes_budget);
            default:                    prdata = '0;
        endcase
    end

    assign cap17    = (17'(r_buffer_limit) < DEPTH_17) ? 17'(r_buffer_limit) : DEPTH_17;
    assign free17   = (cap17 > 17'(r_fill)) ? cap17 - 17'(r_fill) : 17'd0;
    assign avail    = r_fill - r_cons;
    assign fbytes   = 13'(r_len[LW-1:0]) + 13'(lpd_pkg::HEADER_BYTES);
    assign fidx_nx  = (CW+1)'(r_fidx) + (CW+1)'(1);
    assign walk_addr = f_wrap((AW+1)'(r_rh) + (AW+1)'(r_cons) + (AW+1)'(r_hb));
    assign new_fill = r_fill - r_cons;
    assign new_rh   = (new_fill == '0) ? '0 : f_wrap((AW+1)'(r_rh) + (AW+1)'(r_cons));
    assign ring_waddr = f_wrap((AW+1)'(r_rh) + (AW+1)'(r_fill));
    assign ring_raddr = (r_state == lpd_pkg::S_PULL) ? r_dp : walk_addr;
    assign fl_raddr   = fidx_nx[FAW-1:0];

    always_comb begin
        n_payload_limit = r_payload_limit;
        n_buffer_limit  = r_buffer_limit;
        n_frames_budget = r_frames_budget;
        n_bytes_budget  = r_bytes_budget;
        n_state  = r_state;
        n_clen   = r_clen;
        n_rh     = r_rh;
        n_fill   = r_fill;
        n_fault  = r_fault;
        n_open   = r_open;
        n_left   = r_left;
        n_pend   = r_pend;
        n_fidx   = r_fidx;
        n_pleft  = r_pleft;
        n_dp     = r_dp;
        n_cons   = r_cons;
        n_count  = r_count;
        n_budget = r_budget;
        n_hb     = r_hb;
        n_len    = r_len;
        n_first  = r_first;
        n_res    = r_res;
        n_out    = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        ring_we  = 1'b0;
        fl_we    = 1'b0;

        if (cfg_wr) begin
            case (lpd_pkg::t_reg_idx'(paddr[3:2]))
                lpd_pkg::REG_PAYLOAD_LIMIT: n_payload_limit = pwdata[11:0];
                lpd_pkg::REG_BUFFER_LIMIT:  n_buffer_limit  = pwdata[12:0];
                lpd_pkg::REG_FRAMES_BUDGET: n_frames_budget = pwdata[6:0];
                lpd_pkg::REG_BYTES_BUDGET:  n_bytes_budget  = pwdata[12:0];
                default: ;
            endcase
        end

        case (r_state)
            lpd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_clen = i_in_item.chunk_length;
                    case (lpd_pkg::t_cmd'(i_in_item.command))
                        lpd_pkg::CMD_RESET: begin
                            n_rh = '0; n_fill = '0; n_open = 1'b0; n_left = '0;
                            n_pend = '0; n_fidx = '0; n_pleft = '0;
                            n_fault = 1'b0;
                        end
                        lpd_pkg::CMD_START: n_state = lpd_pkg::S_START;
                        lpd_pkg::CMD_DATA: begin
                            if (!r_fault && r_open && r_left != '0) begin
                                n_left = r_left - 16'd1;
                                if (17'(r_fill) < DEPTH_17) begin
                                    ring_we = 1'b1;
                                    n_fill  = r_fill + FW'(1);
                                end
                            end
                        end
                        lpd_pkg::CMD_END:  n_state = lpd_pkg::S_END;
                        lpd_pkg::CMD_PULL: n_state = lpd_pkg::S_PULL;
                        default: ;
                    endcase
                end
            end
            lpd_pkg::S_START: begin
                n_res = '0;
                n_res.kind = lpd_pkg::KIND_STATUS;
                if (r_fault) begin
                    n_res.status = lpd_pkg::ST_FAULTED;
                    n_state = lpd_pkg::S_EMIT;
                end else begin
                    n_pend = '0; n_fidx = '0; n_pleft = '0;
                    if (17'(r_clen) > free17) begin
                        n_rh = '0; n_fill = '0; n_open = 1'b0; n_left = '0;
                        n_fault = 1'b1;
                        n_res.status = lpd_pkg::ST_BUFFER_OVER;
                        n_state = lpd_pkg::S_EMIT;
                    end else begin
                        n_open = 1'b1;
                        n_left = r_clen;
                        n_state = lpd_pkg::S_IDLE;
                    end
                end
            end
            lpd_pkg::S_END: begin
                if (r_fault) begin
                    n_res = '0;
                    n_res.kind = lpd_pkg::KIND_STATUS;
                    n_res.status = lpd_pkg::ST_FAULTED;
                    n_state = lpd_pkg::S_EMIT;
                end else begin
                    n_open = 1'b0; n_left = '0;
                    n_pend = '0; n_fidx = '0; n_pleft = '0;
                    n_cons = '0; n_count = '0; n_budget = 1'b0;
                    n_state = lpd_pkg::S_WCHECK;
                end
            end
            lpd_pkg::S_WCHECK: begin
                n_hb = '0;
                n_state = (17'(avail) >= 17'(lpd_pkg::HEADER_BYTES)) ?
                          lpd_pkg::S_WREAD : lpd_pkg::S_WDONE;
            end
            lpd_pkg::S_WREAD: begin
                // Header bytes come back in the cycle after their read is issued.
                if (r_hb != 3'd0) begin
                    n_len = {r_len[23:0], ring_rdata};
                end
                n_hb = r_hb + 3'd1;
                if (r_hb == 3'(lpd_pkg::HEADER_BYTES)) begin
                    n_state = lpd_pkg::S_WEVAL;
                end
            end
            lpd_pkg::S_WEVAL: begin
                if (r_len > 32'(r_payload_limit)) begin
                    n_rh = '0; n_fill = '0; n_open = 1'b0; n_left = '0;
                    n_pend = '0; n_fidx = '0; n_pleft = '0;
                    n_fault = 1'b1;
                    n_res = '0;
                    n_res.kind = lpd_pkg::KIND_STATUS;
                    n_res.status = lpd_pkg::ST_TOO_LARGE;
                    n_state = lpd_pkg::S_EMIT;
                end else if (17'(avail) < 17'(fbytes)) begin
                    n_state = lpd_pkg::S_WDONE;
                end else if (9'(r_count) >= 9'(r_frames_budget) || 9'(r_count) >= MAXF_9 ||
                             17'(r_cons) + 17'(fbytes) > 17'(r_bytes_budget)) begin
                    n_budget = 1'b1;
                    n_state = lpd_pkg::S_WDONE;
                end else begin
                    fl_we = 1'b1;
                    if (r_count == '0) begin
                        n_first = r_len[LW-1:0];
                    end
                    n_count = r_count + CW'(1);
                    n_cons  = r_cons + FW'(fbytes);
                    n_state = lpd_pkg::S_WCHECK;
                end
            end
            lpd_pkg::S_WDONE: begin
                if (r_cons != '0) begin
                    n_rh   = new_rh;
                    n_fill = new_fill;
                end
                if (r_count != '0) begin
                    n_pend  = r_count;
                    n_fidx  = '0;
                    n_pleft = r_first;
                    n_dp    = f_wrap((AW+1)'(r_rh) + (AW+1)'(lpd_pkg::HEADER_BYTES));
                end
                n_res = '0;
                n_res.kind = lpd_pkg::KIND_STATUS;
                n_res.status = r_budget ? lpd_pkg::ST_BUDGET_OUT :
                               ((r_count != '0) ? lpd_pkg::ST_READY : lpd_pkg::ST_NEED_MORE);
                n_res.frame_count = 7'(r_count);
                n_res.needs_continuation = r_budget;
                n_state = lpd_pkg::S_EMIT;
            end
            lpd_pkg::S_PULL: begin
                n_res = '0;
                if (r_pend == '0) begin
                    n_res.kind = lpd_pkg::KIND_NONE;
                    n_state = lpd_pkg::S_EMIT;
                end else if (r_pleft == '0) begin
                    n_res.kind = lpd_pkg::KIND_EMPTY;
                    n_res.last_of_frame = 1'b1;
                    if (fidx_nx >= (CW+1)'(r_pend)) begin
                        n_pend = '0; n_fidx = '0; n_pleft = '0;
                        n_state = lpd_pkg::S_EMIT;
                    end else begin
                        n_fidx = fidx_nx[CW-1:0];
                        n_dp = f_wrap((AW+1)'(r_dp) + (AW+1)'(lpd_pkg::HEADER_BYTES));
                        n_state = lpd_pkg::S_LEN;
                    end
                end else begin
                    n_state = lpd_pkg::S_PULLD;
                end
            end
            lpd_pkg::S_PULLD: begin
                n_res = '0;
                n_res.kind = lpd_pkg::KIND_PAYLOAD;
                n_res.data_out = ring_rdata;
                n_pleft = r_pleft - LW'(1);
                n_dp = f_wrap((AW+1)'(r_dp) + (AW+1)'(1));
                n_state = lpd_pkg::S_EMIT;
                if (r_pleft == LW'(1)) begin
                    n_res.last_of_frame = 1'b1;
                    if (fidx_nx >= (CW+1)'(r_pend)) begin
                        n_pend = '0; n_fidx = '0; n_pleft = '0;
                    end else begin
                        n_fidx = fidx_nx[CW-1:0];
                        n_dp = f_wrap((AW+1)'(r_dp) + (AW+1)'(lpd_pkg::HEADER_BYTES + 1));
                        n_state = lpd_pkg::S_LEN;
                    end
                end
            end
            lpd_pkg::S_LEN: begin
                n_pleft = fl_rdata;
                n_state = lpd_pkg::S_EMIT;
            end
            lpd_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                    n_state = lpd_pkg::S_IDLE;
                end
            end
            default: n_state = lpd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lpd_pkg::S_IDLE;
            r_payload_limit <= lpd_pkg::PAYLOAD_LIMIT_RST;
            r_buffer_limit  <= lpd_pkg::BUFFER_LIMIT_RST;
            r_frames_budget <= lpd_pkg::FRAMES_BUDGET_RST;
            r_bytes_budget  <= lpd_pkg::BYTES_BUDGET_RST;
            r_rh     <= '0;
            r_fill   <= '0;
            r_fault  <= 1'b0;
            r_open   <= 1'b0;
            r_left   <= '0;
            r_pend   <= '0;
            r_fidx   <= '0;
            r_pleft  <= '0;
            r_dp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_payload_limit <= n_payload_limit;
            r_buffer_limit  <= n_buffer_limit;
            r_frames_budget <= n_frames_budget;
            r_bytes_budget  <= n_bytes_budget;
            r_rh     <= n_rh;
            r_fill   <= n_fill;
            r_fault  <= n_fault;
            r_open   <= n_open;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_fidx   <= n_fidx;
            r_pleft  <= n_pleft;
            r_dp     <= n_dp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clen   <= n_clen;
        r_cons   <= n_cons;
        r_count  <= n_count;
        r_budget <= n_budget;
        r_hb     <= n_hb;
        r_len    <= n_len;
        r_first  <= n_first;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule

>>> design/lpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
